// ===== sv/eikonal_grid_node_update_assert.svh =====
// Assertion macros shared by the RTL of the eikonal cell update.
`ifndef EIKONAL_GRID_NODE_UPDATE_ASSERT_SVH
`define EIKONAL_GRID_NODE_UPDATE_ASSERT_SVH
`ifndef SYNTH
`define EGNU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("eikonal cell update: same-cycle check failed");
`define EGNU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("eikonal cell update: next-cycle check failed");
`else
`define EGNU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define EGNU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/egnu_pkg.sv =====
package egnu_pkg;

	localparam int unsigned DIV_BITS = 44;
	localparam int unsigned DIV_PER = 4;
	localparam int unsigned DIV_STG = DIV_BITS / DIV_PER;
	localparam int unsigned SQ_BITS = 45;
	localparam int unsigned SQ_PER = 3;
	localparam int unsigned SQ_STG = SQ_BITS / SQ_PER;
	// Stage map: 0 intake, then divider, three squaring stages, root, final.
	localparam int unsigned ST_DIV0 = 1;
	localparam int unsigned ST_MUL = ST_DIV0 + DIV_STG;
	localparam int unsigned ST_SUM = ST_MUL + 1;
	localparam int unsigned ST_SUB = ST_SUM + 1;
	localparam int unsigned ST_SQ0 = ST_SUB + 1;
	localparam int unsigned ST_FIN = ST_SQ0 + SQ_STG;
	localparam int unsigned NST = ST_FIN + 1;

	localparam logic [31:0] VAL_INF = 32'hFFFF_FFFF;
	localparam logic [31:0] GRID_SCALE_RST = 32'h0001_0000;

	typedef enum logic [1:0] {
		OUT_OBSTACLE = 2'd0,
		OUT_NO_SEC = 2'd1,
		OUT_REJECTED = 2'd2,
		OUT_INTERP = 2'd3
	} outcome_t;

	typedef enum logic {
		REG_GRID_SCALE = 1'b0,
		REG_OBST_EPS = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [15:0] meta;
		logic [31:0] p;
		logic [31:0] s;
		logic [1:0] slot;
		logic obst;
		outcome_t outc;
		logic [15:0] rem_d;
		logic [DIV_BITS-1:0] dq;
		logic [31:0] d;
		logic [63:0] dsq;
		logic [43:0] hh;
		logic [43:0] hl;
		logic [43:0] ll;
		logic [31:0] dir;
		logic [89:0] rad;
		logic [47:0] rem_s;
		logic [SQ_BITS-1:0] root;
	} item_t;

	function automatic item_t stage_step(input int unsigned i, input item_t x);
		item_t y;
		logic [16:0] r2;
		logic [47:0] rs;
		logic [47:0] trial;
		logic [44:0] sum45;
		logic [89:0] two_r2;
		logic [45:0] fin;
		y = x;
		if (i >= ST_DIV0 && i < ST_MUL) begin
			if (i == ST_DIV0) begin
				y.dsq = x.d * x.d;
			end
			for (int k = 0; k < DIV_PER; k++) begin
				r2 = {y.rem_d, y.dq[DIV_BITS-1]};
				y.dq = {y.dq[DIV_BITS-2:0], 1'b0};
				if (r2 >= {1'b0, y.meta}) begin
					r2 = r2 - {1'b0, y.meta};
					y.dq[0] = 1'b1;
				end
				y.rem_d = r2[15:0];
			end
		end else if (i == ST_MUL) begin
			y.hh = x.dq[43:22] * x.dq[43:22];
			y.hl = x.dq[43:22] * x.dq[21:0];
			y.ll = x.dq[21:0] * x.dq[21:0];
			sum45 = {13'd0, x.p} + {1'b0, x.dq};
			y.dir = (sum45[44:32] != 13'd0) ? VAL_INF : sum45[31:0];
			if (x.obst) begin
				y.outc = OUT_OBSTACLE;
			end else if (x.slot == 2'd0) begin
				y.outc = OUT_NO_SEC;
			end else if (x.s >= x.p && {1'b0, x.dq} <= {13'd0, x.s - x.p}) begin
				y.outc = OUT_REJECTED;
			end else begin
				y.outc = OUT_INTERP;
			end
		end else if (i == ST_SUM) begin
			y.rad = {1'b0, x.hh, 45'd0} + {22'd0, x.hl, 24'd0} + {45'd0, x.ll, 1'b0};
		end else if (i == ST_SUB) begin
			two_r2 = x.rad;
			y.rad = (two_r2 < {26'd0, x.dsq}) ? 90'd0 : two_r2 - {26'd0, x.dsq};
			y.rem_s = '0;
			y.root = '0;
		end else if (i >= ST_SQ0 && i < ST_FIN) begin
			for (int k = 0; k < SQ_PER; k++) begin
				rs = {y.rem_s[45:0], y.rad[89:88]};
				y.rad = {y.rad[87:0], 2'b00};
				trial = {1'b0, y.root, 2'b01};
				if (rs >= trial) begin
					rs = rs - trial;
					y.root = {y.root[SQ_BITS-2:0], 1'b1};
				end else begin
					y.root = {y.root[SQ_BITS-2:0], 1'b0};
				end
				y.rem_s = rs;
			end
		end else if (i == ST_FIN) begin
			fin = {14'd0, x.p} + {14'd0, x.s} + {1'b0, x.root};
			unique case (x.outc)
				OUT_OBSTACLE: begin
					y.dir = VAL_INF;
					y.slot = 2'd0;
				end
				OUT_NO_SEC, OUT_REJECTED: begin
					y.slot = 2'd0;
				end
				OUT_INTERP: begin
					y.dir = (fin[45:33] != 13'd0) ? VAL_INF : fin[32:1];
				end
				default: begin
					y.slot = 2'd0;
				end
			endcase
		end
		return y;
	endfunction

endpackage

// ===== sv/eikonal_grid_node_update.sv =====
// Channel  Direction  Handshake             Payload
// in       into block in_valid / in_stall   cell_speed .. third_axis
// out      from block out_valid / out_stall cell_value, outcome, secondary_slot
// cfg      into block cfg_we                cfg_index, cfg_data
//
// One word enters per cycle while the output word is not stalled; a word leaves
// through 31 register stages (intake, 11 divider stages of four quotient bits, three
// squaring stages, 15 root stages of three bits, final).
// The whole pipeline holds while the output word is stalled.
// Reset empties the pipeline and loads the register reset values.
module eikonal_grid_node_update import egnu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [15:0] cell_speed,
	input logic [31:0] lead_value,
	input logic primary_axis,
	input logic [1:0] extra_count,
	input logic [31:0] first_value,
	input logic first_axis,
	input logic [31:0] second_value,
	input logic second_axis,
	input logic [31:0] third_value,
	input logic third_axis,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] cell_value,
	output logic [1:0] outcome,
	output logic [1:0] secondary_slot
);

`include "eikonal_grid_node_update_assert.svh"

	logic [31:0] grid_scale_q;
	logic [15:0] obst_eps_q;
	item_t stage_s [NST];
	item_t nxt [NST];
	logic [NST-1:0] valid_s;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_scale_q <= GRID_SCALE_RST;
			obst_eps_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_GRID_SCALE: grid_scale_q <= cfg_data;
				REG_OBST_EPS: obst_eps_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign adv = !(valid_s[NST-1] && out_stall);
	assign in_stall = !adv;

	always_comb begin
		nxt[0] = '0;
		nxt[0].meta = cell_speed;
		nxt[0].p = lead_value;
		nxt[0].obst = (cell_speed <= obst_eps_q) || (cell_speed == 16'd0);
		nxt[0].outc = OUT_OBSTACLE;
		// First further neighbour that lies on the other axis.
		if (extra_count >= 2'd1 && first_axis != primary_axis) begin
			nxt[0].slot = 2'd1;
			nxt[0].s = first_value;
		end else if (extra_count >= 2'd2 && second_axis != primary_axis) begin
			nxt[0].slot = 2'd2;
			nxt[0].s = second_value;
		end else if (extra_count == 2'd3 && third_axis != primary_axis) begin
			nxt[0].slot = 2'd3;
			nxt[0].s = third_value;
		end else begin
			nxt[0].slot = 2'd0;
			nxt[0].s = first_value;
		end
		nxt[0].d = (nxt[0].s >= lead_value) ? nxt[0].s - lead_value
			: lead_value - nxt[0].s;
		nxt[0].rem_d = '0;
		nxt[0].dq = {grid_scale_q, 12'd0};
		for (int i = 1; i < NST; i++) begin
			nxt[i] = stage_step(i, stage_s[i-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stage_s[0] <= nxt[0];
			for (int i = 1; i < NST; i++) begin
				stage_s[i] <= nxt[i];
			end
		end
	end

	assign out_valid = valid_s[NST-1];
	assign cell_value = stage_s[NST-1].dir;
	assign outcome = stage_s[NST-1].outc;
	assign secondary_slot = stage_s[NST-1].slot;

	`EGNU_ASSERT_SAME(a_obst_inf, clk, arst_n, out_valid && outcome == OUT_OBSTACLE, cell_value == VAL_INF)
	`EGNU_ASSERT_SAME(a_slot_unused, clk, arst_n, out_valid && outcome != OUT_INTERP, secondary_slot == 2'd0)
	`EGNU_ASSERT_SAME(a_slot_used, clk, arst_n, out_valid && outcome == OUT_INTERP, secondary_slot != 2'd0)
	`EGNU_ASSERT_NEXT(a_hold_word, clk, arst_n, out_valid && out_stall, out_valid && $stable(valid_s))

endmodule

// ===== verif/tb_eikonal_grid_node_update.sv =====
`timescale 1ns / 1ps

module tb_eikonal_grid_node_update import egnu_pkg::*; ();

	typedef struct packed {
		logic [15:0] meta;
		logic [31:0] p;
		logic paxis;
		logic [1:0] cnt;
		logic [31:0] v1;
		logic v1x;
		logic [31:0] v2;
		logic v2x;
		logic [31:0] v3;
		logic v3x;
	} cell_t;

	typedef struct packed {
		logic [31:0] value;
		outcome_t outc;
		logic [1:0] slot;
	} update_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	cell_t cur = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] cell_value;
	logic [1:0] outcome;
	logic [1:0] secondary_slot;

	logic [31:0] scale_q = GRID_SCALE_RST;
	logic [15:0] eps_q = '0;
	update_t pending_updates[$];
	int mismatches = 0;
	int hold_cycles = 0;
	bit random_stall = 1'b0;

	always #2 clk = ~clk;

	eikonal_grid_node_update DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.cell_speed(cur.meta), .lead_value(cur.p), .primary_axis(cur.paxis),
		.extra_count(cur.cnt),
		.first_value(cur.v1), .first_axis(cur.v1x),
		.second_value(cur.v2), .second_axis(cur.v2x),
		.third_value(cur.v3), .third_axis(cur.v3x),
		.out_valid(out_valid), .out_stall(out_stall),
		.cell_value(cell_value), .outcome(outcome), .secondary_slot(secondary_slot)
	);

	function automatic logic [31:0] clamp32(logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic update_t solve_cell(cell_t c);
		update_t r;
		logic [44:0] radius;
		logic [31:0] vals[3];
		logic axes[3];
		logic [1:0] slot;
		logic [31:0] s;
		logic [31:0] d;
		logic [95:0] rad2;
		logic [47:0] root;
		logic [95:0] rem;
		logic [95:0] trial;
		vals[0] = c.v1; vals[1] = c.v2; vals[2] = c.v3;
		axes[0] = c.v1x; axes[1] = c.v2x; axes[2] = c.v3x;
		slot = 2'd0;
		r = '0;
		if (c.meta <= eps_q || c.meta == 16'd0) begin
			r.value = 32'hFFFF_FFFF;
			r.outc = OUT_OBSTACLE;
			return r;
		end
		radius = ({13'd0, scale_q} << 12) / c.meta;
		for (int k = 2; k >= 0; k--)
			if (k < c.cnt && axes[k] != c.paxis) slot = 2'(k + 1);
		if (slot == 2'd0) begin
			r.value = clamp32(radius + c.p);
			r.outc = OUT_NO_SEC;
			return r;
		end
		s = vals[slot - 1];
		// The gap is signed, so a secondary below the primary is never rejected.
		if ($signed({19'd0, radius}) <= $signed({32'd0, s}) - $signed({32'd0, c.p})) begin
			r.value = clamp32(radius + c.p);
			r.outc = OUT_REJECTED;
			return r;
		end
		d = (s >= c.p) ? s - c.p : c.p - s;
		rad2 = 96'(radius) * 96'(radius) * 2;
		rad2 = (rad2 < 96'(d) * 96'(d)) ? 96'd0 : rad2 - 96'(d) * 96'(d);
		root = '0;
		rem = '0;
		for (int i = 47; i >= 0; i--) begin
			rem = (rem << 2) | 96'((rad2 >> (2 * i)) & 96'd3);
			trial = {root, 2'b01};
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[46:0], 1'b1};
			end else begin
				root = {root[46:0], 1'b0};
			end
		end
		r.value = clamp32((64'(c.p) + 64'(s) + 64'(root)) >> 1);
		r.outc = OUT_INTERP;
		r.slot = slot;
		return r;
	endfunction

	always @(posedge clk) begin
		if (in_valid && !in_stall)
			pending_updates.push_back(solve_cell(cur));
		if (out_valid && !out_stall) begin
			if (pending_updates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: value %h outcome %0d slot %0d",
						cell_value, outcome, secondary_slot);
			end else begin
				update_t e;
				e = pending_updates.pop_front();
				if (e.value !== cell_value || e.outc !== outcome ||
						e.slot !== secondary_slot) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
							e.value, e.outc, e.slot, cell_value, outcome,
							secondary_slot);
				end
			end
		end
	end

	// Receiver: a long hold-off when requested, otherwise its own stall pattern.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (random_stall) begin
			out_stall <= ($urandom_range(0, 3) == 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic offer(cell_t c);
		cur <= c;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic pause(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_updates.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_GRID_SCALE) scale_q = data;
		else eps_q = data[15:0];
		@(posedge clk);
	endtask

	function automatic logic [31:0] any32();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	// Mostly ascending neighbors near the primary so interpolation is reached.
	function automatic cell_t random_cell();
		cell_t c;
		logic [31:0] base;
		c.meta = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
			16'($urandom_range(1, 16'h2000));
		if ($urandom_range(0, 9) == 0) c.meta = 16'hFFFF;
		base = ($urandom_range(0, 9) == 0) ? any32() : $urandom_range(0, 32'h0100_0000);
		c.p = base;
		c.paxis = 1'($urandom);
		c.cnt = 2'($urandom);
		c.v1 = base + $urandom_range(0, 32'h0003_0000);
		c.v2 = c.v1 + $urandom_range(0, 32'h0003_0000);
		c.v3 = c.v2 + $urandom_range(0, 32'h0003_0000);
		if ($urandom_range(0, 7) == 0) begin
			c.v1 = any32(); c.v2 = any32(); c.v3 = any32();
		end
		c.v1x = 1'($urandom); c.v2x = 1'($urandom); c.v3x = 1'($urandom);
		return c;
	endfunction

	typedef struct {
		cell_t c;
		bit known;
		update_t r;
	} row_t;

	initial begin
		row_t rows[$];
		row_t row;
		int sent;
		int burst;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: obstacles and extremes have values known on sight.
		row.known = 1'b1;
		row.c = '0;
		row.r = '{32'hFFFF_FFFF, OUT_OBSTACLE, 2'd0};
		rows.push_back(row);
		row.c.p = 32'h1234_5678; row.c.cnt = 2'd3;
		rows.push_back(row);
		row.c = '0; row.c.meta = 16'h1000; row.c.p = 32'd0;
		row.r = '{32'h0001_0000, OUT_NO_SEC, 2'd0};
		rows.push_back(row);
		row.c.p = 32'hFFFF_FFFF;
		row.r = '{32'hFFFF_FFFF, OUT_NO_SEC, 2'd0};
		rows.push_back(row);
		row.c = '{16'h1000, 32'd0, 1'b1, 2'd1, 32'h0002_0000, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0};
		row.r = '{32'h0001_0000, OUT_REJECTED, 2'd0};
		rows.push_back(row);
		row.known = 1'b0;
		row.c = '{16'h1000, 32'h0001_0000, 1'b0, 2'd1, 32'h0001_0000, 1'b1, 0, 0, 0, 0};
		rows.push_back(row);
		row.c = '{16'h1000, 32'h0001_0000, 1'b0, 2'd3, 32'h0001_8000, 1'b0,
			32'h0001_8000, 1'b0, 32'h0001_4000, 1'b1};
		rows.push_back(row);
		row.c = '{16'h1000, 32'h0001_0000, 1'b1, 2'd2, 32'h0001_0000, 1'b1,
			32'h0001_4000, 1'b0, 32'hFFFF_FFFF, 1'b0};
		rows.push_back(row);
		row.c = '{16'h0800, 32'h0005_0000, 1'b0, 2'd1, 32'h0000_0000, 1'b1, 0, 0, 0, 0};
		rows.push_back(row);
		row.c = '{16'h0001, 32'hFFFF_0000, 1'b1, 2'd1, 32'hFFFF_FFFF, 1'b0, 0, 0, 0, 0};
		rows.push_back(row);
		row.c = '{16'hFFFF, 32'hFFFF_FFFF, 1'b0, 2'd3, 32'hFFFF_FFFF, 1'b1,
			32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1};
		rows.push_back(row);
		row.c = '{16'hFFFF, 32'h0, 1'b1, 2'd2, 32'h0, 1'b1, 32'h0, 1'b0, 32'h0, 1'b1};
		rows.push_back(row);

		foreach (rows[i]) begin
			if (rows[i].known && solve_cell(rows[i].c) !== rows[i].r) begin
				mismatches++;
				$display("directed row %0d disagrees with its typed result", i);
			end
			offer(rows[i].c);
		end
		drain();

		write_reg(REG_OBST_EPS, 32'h0000_0800);
		write_reg(REG_GRID_SCALE, 32'hFFFF_FFFF);
		offer('{16'h0800, 32'd5, 1'b0, 2'd0, 0, 0, 0, 0, 0, 0});
		offer('{16'h0801, 32'd5, 1'b0, 2'd1, 32'd9, 1'b1, 0, 0, 0, 0});
		offer('{16'h0001, 32'd5, 1'b0, 2'd1, 32'd9, 1'b1, 0, 0, 0, 0});
		drain();

		random_stall = 1'b1;
		sent = 0;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin write_reg(REG_GRID_SCALE, GRID_SCALE_RST);
					write_reg(REG_OBST_EPS, 32'd0); end
				1: begin write_reg(REG_GRID_SCALE, 32'd0);
					write_reg(REG_OBST_EPS, 32'hFFFF); end
				2: begin write_reg(REG_GRID_SCALE, 32'hFFFF_FFFF);
					write_reg(REG_OBST_EPS, 32'h0010); end
				3: begin write_reg(REG_GRID_SCALE, $urandom);
					write_reg(REG_OBST_EPS, $urandom_range(0, 16'h0400)); end
				default: begin write_reg(REG_GRID_SCALE, $urandom_range(1, 32'h0004_0000));
					write_reg(REG_OBST_EPS, 32'd1); end
			endcase
			if (phase == 2) hold_cycles <= 150;
			while (sent < (phase + 1) * 100) begin
				burst = $urandom_range(1, 20);
				for (int b = 0; b < burst; b++) begin
					offer(random_cell());
					sent++;
				end
				if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
			end
			drain();
		end

		if (mismatches == 0 && pending_updates.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
